@@ hw/rtl/bni_pkg.sv @@
// ----------------------------------------------------------------------------
// bni_pkg
// Shared types and constants for the batch normalization inference block.
// ----------------------------------------------------------------------------
package bni_pkg;

   localparam int DefNumChannels = 64;
   localparam int ChanW          = 6;
   localparam int ValW           = 32;
   localparam int VarW           = 31;
   localparam int ProdW          = 65;
   localparam int RootW          = 24;
   localparam int QuotW          = 65;
   localparam int DivSteps       = 65;
   localparam int SqrtSteps      = 24;
   localparam logic [VarW:0] EpsQ16 = 32'd7;

   localparam logic CmdLoad   = 1'b0;
   localparam logic CmdSample = 1'b1;

   // request and response tdata widths
   localparam int ReqDataW = 168;
   localparam int RspDataW = 40;

   // sideband that rides along the pipe
   typedef struct packed {
      logic [ChanW-1:0] channel;
      logic             row_end;
      logic             in_range;
   } side_type;

endpackage

@@ hw/rtl/batch_norm_inference.sv @@
// ----------------------------------------------------------------------------
// batch_norm_inference
// Per-channel batch normalization: (x - mean) * gamma / sqrt(var + eps) + beta
//
//   channel  dir  tdata fields (low bit up)                         tlast    tuser
//   req_     in   channel, sample, gamma, beta, mean, variance      row_end  command
//   rsp_     out  out_value, out_channel, saturated                 row_end  -
//
// one item per cycle while the skid has room; a request beat passes
// three front stages, 25 square root stages, 66 divider stages, output register.
// load beats write the tables and leave no result.
// reset clears all valid bits; table contents are undefined until loaded.
// a stall on rsp_ freezes the whole pipe once the skid is full; a two-entry skid register
// keeps req_tready independent of rsp_tready in the same cycle.
// ----------------------------------------------------------------------------
module batch_norm_inference #(
   parameter int NUM_CHANNELS = bni_pkg::DefNumChannels
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // channel[5:0], sample[37:6], gamma[69:38], beta[101:70], mean[133:102],
   // variance[164:134], zero fill
   input  logic [bni_pkg::ReqDataW-1:0] req_tdata,
   input  logic         req_tlast,
   // command
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_value[31:0], out_channel[37:32], saturated[38], zero fill
   output logic [bni_pkg::RspDataW-1:0] rsp_tdata,
   output logic         rsp_tlast
);

   localparam int CW = bni_pkg::ChanW;
   localparam int VW = bni_pkg::ValW;
   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SW = $bits(bni_pkg::side_type);

   // unpack request
   logic [CW-1:0]          r_chan;
   logic signed [VW-1:0]   r_sample;
   logic [VW-1:0]          r_gamma, r_beta, r_mean;
   logic [bni_pkg::VarW-1:0] r_var;
   logic                   r_in_range;
   logic [AW-1:0]          r_addr;
   logic                   advance;
   logic                   in_fire;

   assign r_chan   = req_tdata[5:0];
   assign r_sample = req_tdata[37:6];
   assign r_gamma  = req_tdata[69:38];
   assign r_beta   = req_tdata[101:70];
   assign r_mean   = req_tdata[133:102];
   assign r_var    = req_tdata[164:134];
   assign r_in_range = (32'(r_chan) < 32'(NUM_CHANNELS));
   assign r_addr   = AW'(r_chan);

   // the whole pipe moves when the skid buffer has room
   logic [1:0] skid_cnt_ff;
   logic [1:0] in_flight;
   assign req_tready = advance;
   assign in_fire    = req_tvalid & req_tready;

   logic wr_en;
   assign wr_en = in_fire & (req_tuser == bni_pkg::CmdLoad) & r_in_range;

   logic rd_en;
   assign rd_en = advance;

   logic [VW-1:0] t_gamma, t_beta, t_mean;
   logic [bni_pkg::VarW-1:0] t_var;

   bni_ram #(.Width(VW), .Depth(NUM_CHANNELS)) u_gamma (
      .clock, .wr_en, .wr_addr(r_addr), .wr_data(r_gamma),
      .rd_en, .rd_addr(r_addr), .rd_data(t_gamma));
   bni_ram #(.Width(VW), .Depth(NUM_CHANNELS)) u_beta (
      .clock, .wr_en, .wr_addr(r_addr), .wr_data(r_beta),
      .rd_en, .rd_addr(r_addr), .rd_data(t_beta));
   bni_ram #(.Width(VW), .Depth(NUM_CHANNELS)) u_mean (
      .clock, .wr_en, .wr_addr(r_addr), .wr_data(r_mean),
      .rd_en, .rd_addr(r_addr), .rd_data(t_mean));
   bni_ram #(.Width(bni_pkg::VarW), .Depth(NUM_CHANNELS)) u_var (
      .clock, .wr_en, .wr_addr(r_addr), .wr_data(r_var),
      .rd_en, .rd_addr(r_addr), .rd_data(t_var));

   // stage a: table read in flight, sample and sideband beside it
   logic                 a_vld_ff;
   logic signed [VW-1:0] a_sample_ff;
   bni_pkg::side_type    a_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= in_fire & (req_tuser == bni_pkg::CmdSample);
      end
      if (advance) begin
         a_sample_ff <= r_sample;
         a_side_ff   <= '{channel: r_chan, row_end: req_tlast, in_range: r_in_range};
      end
   end

   // stage b: difference against the mean, radicand formed
   logic                 b_vld_ff;
   logic signed [VW:0]   b_diff_ff;
   logic signed [VW-1:0] b_gamma_ff, b_beta_ff;
   logic [VW-1:0]        b_rad_ff;
   bni_pkg::side_type    b_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (advance) begin
         b_vld_ff <= a_vld_ff;
      end
      if (advance) begin
         b_diff_ff  <= $signed({a_sample_ff[VW-1], a_sample_ff})
                     - $signed({t_mean[VW-1], t_mean});
         b_gamma_ff <= t_gamma;
         b_beta_ff  <= t_beta;
         b_rad_ff   <= {1'b0, t_var} + bni_pkg::EpsQ16;
         b_side_ff  <= a_side_ff;
      end
   end

   // stage c: product while the root is being built; product waits in the
   // sqrt pipe's sideband
   localparam int PW = bni_pkg::ProdW;
   logic signed [PW-1:0] c_prod;
   logic [PW-2:0]        c_mag;
   logic                 c_neg;
   assign c_prod = PW'(b_diff_ff * b_gamma_ff);
   assign c_neg  = c_prod[PW-1];
   assign c_mag  = c_neg ? (PW-1)'(-c_prod) : c_prod[PW-2:0];

   localparam int QW = PW - 1 + 1 + VW + SW;
   logic                      s_vld;
   logic [bni_pkg::RootW-1:0] s_root;
   logic [QW-1:0]             s_data;
   logic                      p_vld_ff;
   logic [QW-1:0]             p_data_ff;
   logic [VW-1:0]             p_rad_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (advance) begin
         p_vld_ff <= b_vld_ff;
      end
      if (advance) begin
         p_data_ff <= {c_mag, c_neg, b_beta_ff, b_side_ff};
         p_rad_ff  <= b_rad_ff;
      end
   end

   bni_sqrt_pipe #(.DataW(QW)) u_sqrt (
      .clock, .reset, .advance,
      .in_valid(p_vld_ff), .in_rad(p_rad_ff), .in_data(p_data_ff),
      .out_valid(s_vld), .out_root(s_root), .out_data(s_data));

   localparam int DDW = VW + SW;
   logic                     d_vld;
   logic signed [bni_pkg::QuotW-1:0] d_quot;
   logic [DDW-1:0]           d_data;

   bni_div_pipe #(.DataW(DDW)) u_div (
      .clock, .reset, .advance,
      .in_valid(s_vld), .in_mag(s_data[QW-1 -: PW-1]), .in_neg(s_data[DDW]),
      .in_div(s_root), .in_data(s_data[DDW-1:0]),
      .out_valid(d_vld), .out_quot(d_quot), .out_data(d_data));

   // final add of beta and saturation; out-of-range channels give zero
   bni_pkg::side_type    e_side;
   logic signed [VW-1:0] e_beta;
   logic signed [bni_pkg::QuotW:0] e_sum;
   logic                 e_hi, e_lo;
   logic [VW-1:0]        e_val;
   logic                 e_sat;
   assign e_side = d_data[SW-1:0];
   assign e_beta = d_data[DDW-1:SW];
   assign e_sum  = $signed({d_quot[bni_pkg::QuotW-1], d_quot}) + e_beta;
   assign e_hi   = e_sum > $signed((bni_pkg::QuotW+1)'(32'h7fff_ffff));
   assign e_lo   = e_sum < -$signed((bni_pkg::QuotW+1)'(33'h0_8000_0000));
   always_comb begin
      if (!e_side.in_range) begin
         e_val = '0;
         e_sat = 1'b0;
      end else if (e_hi) begin
         e_val = 32'h7fff_ffff;
         e_sat = 1'b1;
      end else if (e_lo) begin
         e_val = 32'h8000_0000;
         e_sat = 1'b1;
      end else begin
         e_val = e_sum[VW-1:0];
         e_sat = 1'b0;
      end
   end

   // output register plus one skid entry
   logic [VW+CW+2-1:0] e_beat;
   assign e_beat = {e_side.row_end, e_sat, e_side.channel, e_val};
   logic [VW+CW+2-1:0] q0_ff, q1_ff;
   logic pop, push;
   assign push = advance & d_vld;
   assign pop  = rsp_tvalid & rsp_tready;
   assign in_flight = skid_cnt_ff;
   // keep a free slot so the pipe can always drain its head beat
   assign advance = (skid_cnt_ff != 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_cnt_ff <= '0;
      end else begin
         skid_cnt_ff <= skid_cnt_ff + 2'(push) - 2'(pop);
      end
      if (pop) begin
         q0_ff <= (skid_cnt_ff == 2'd2) ? q1_ff : e_beat;
      end else if (push && skid_cnt_ff == 2'd0) begin
         q0_ff <= e_beat;
      end
      if (push && ((skid_cnt_ff == 2'd1 && !pop) || (skid_cnt_ff == 2'd2))) begin
         q1_ff <= e_beat;
      end
   end

   assign rsp_tvalid = (in_flight != 2'd0);
   assign rsp_tdata  = {1'b0, q0_ff[VW+CW:0]};
   assign rsp_tlast  = q0_ff[VW+CW+1];

   // pipe only moves when the skid has room
   assert property (@(posedge clock) disable iff (reset) skid_cnt_ff != 2'd3)
      else $error("skid overflow");
   assert property (@(posedge clock) disable iff (reset)
      !advance |-> skid_cnt_ff != 2'd0)
      else $error("pipe stalled with empty skid");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result beat dropped");

endmodule

@@ hw/rtl/bni_ram.sv @@
// ----------------------------------------------------------------------------
// bni_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bni_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bni_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// bni_sqrt_pipe
// Pipelined restoring square root, one result bit per stage.
// Root of (v << 16) where v is 32 bits; data rides along with its valid.
// ----------------------------------------------------------------------------
module bni_sqrt_pipe #(
   parameter int DataW = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [bni_pkg::VarW:0]    in_rad,
   input  logic [DataW-1:0]          in_data,
   output logic                      out_valid,
   output logic [bni_pkg::RootW-1:0] out_root,
   output logic [DataW-1:0]          out_data
);

   localparam int N  = bni_pkg::SqrtSteps;
   localparam int RW = 48;
   localparam int EW = 26;

   logic          vld_ff  [N+1];
   logic [RW-1:0] rad_ff  [N+1];
   logic [EW-1:0] rem_ff  [N+1];
   logic [N-1:0]  root_ff [N+1];
   logic [DataW-1:0] dat_ff [N+1];

   // stage zero latches the input
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         rad_ff[0]  <= {in_rad, 16'd0};
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         dat_ff[0]  <= in_data;
      end
   end

   // one root bit per stage: two radicand bits shift in
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [EW-1:0] rem_sh;
      logic [EW-1:0] trial;
      logic          take;
      always_comb begin
         rem_sh = {rem_ff[s][EW-3:0], rad_ff[s][RW-1 -: 2]};
         trial  = {1'b0, root_ff[s][N-2:0], 2'b01};
         take   = rem_sh >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (advance) begin
            rad_ff[s+1]  <= {rad_ff[s][RW-3:0], 2'b00};
            rem_ff[s+1]  <= take ? rem_sh - trial : rem_sh;
            root_ff[s+1] <= {root_ff[s][N-2:0], take};
            dat_ff[s+1]  <= dat_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_root  = root_ff[N];
   assign out_data  = dat_ff[N];

endmodule

@@ hw/rtl/bni_div_pipe.sv @@
// ----------------------------------------------------------------------------
// bni_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with round
// to nearest (ties away) on the magnitude and sign applied at the end.
// ----------------------------------------------------------------------------
module bni_div_pipe #(
   parameter int DataW = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [bni_pkg::ProdW-2:0] in_mag,
   input  logic                      in_neg,
   input  logic [bni_pkg::RootW-1:0] in_div,
   input  logic [DataW-1:0]          in_data,
   output logic                      out_valid,
   output logic signed [bni_pkg::QuotW-1:0] out_quot,
   output logic [DataW-1:0]          out_data
);

   localparam int N  = bni_pkg::DivSteps;
   localparam int DW = bni_pkg::RootW;

   logic          vld_ff [N+1];
   logic [N-1:0]  num_ff [N+1];
   logic [DW:0]   rem_ff [N+1];
   logic [DW-1:0] den_ff [N+1];
   logic          neg_ff [N+1];
   logic [DataW-1:0] dat_ff [N+1];

   // stage zero adds half the divisor for rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         num_ff[0] <= {1'b0, in_mag} + N'({1'b0, in_div[DW-1:1]});
         rem_ff[0] <= '0;
         den_ff[0] <= in_div;
         neg_ff[0] <= in_neg;
         dat_ff[0] <= in_data;
      end
   end

   // one quotient bit per stage, quotient shifts into the numerator
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [DW+1:0] rem_sh;
      logic          take;
      always_comb begin
         rem_sh = {rem_ff[s], num_ff[s][N-1]};
         take   = rem_sh >= {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (advance) begin
            rem_ff[s+1] <= take ? DW'(rem_sh - {2'b00, den_ff[s]}) + (DW+1)'(0)
                                : rem_sh[DW:0];
            num_ff[s+1] <= {num_ff[s][N-2:0], take};
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            dat_ff[s+1] <= dat_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_quot  = neg_ff[N] ? -$signed(num_ff[N]) : $signed(num_ff[N]);
   assign out_data  = dat_ff[N];

endmodule
